@@ src/obtb_pkg.sv @@
// Shared types and constants of the oriented box bounds block.
// No dependencies; the top level, the front end and the engine import this package.
`default_nettype none

package obtb_pkg;

    typedef struct packed {
        logic signed [31:0] m_r0_c0;
        logic signed [31:0] m_r0_c1;
        logic signed [31:0] m_r0_c2;
        logic signed [31:0] m_r0_c3;
        logic signed [31:0] m_r1_c0;
        logic signed [31:0] m_r1_c1;
        logic signed [31:0] m_r1_c2;
        logic signed [31:0] m_r1_c3;
        logic signed [31:0] m_r2_c0;
        logic signed [31:0] m_r2_c1;
        logic signed [31:0] m_r2_c2;
        logic signed [31:0] m_r2_c3;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               last;
    } out_word_t;

    // Corner registers, element 0 is x.
    typedef struct packed {
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
    } box_cfg_t;

    typedef enum logic [2:0] {
        REG_A_X = 3'd0,
        REG_A_Y = 3'd1,
        REG_A_Z = 3'd2,
        REG_B_X = 3'd3,
        REG_B_Y = 3'd4,
        REG_B_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        KIND_MAX    = 3'd0,
        KIND_MIN    = 3'd1,
        KIND_CENTER = 3'd2,
        KIND_AXIS_X = 3'd3,
        KIND_AXIS_Y = 3'd4,
        KIND_AXIS_Z = 3'd5,
        KIND_HALF   = 3'd6
    } kind_t;

    // Bit c set means the corner takes coordinate c from corner B.
    function automatic logic [2:0] corner_sel(input logic [2:0] idx);
        logic [2:0] s;
        case (idx)
            3'd0:    s = 3'b000;
            3'd1:    s = 3'b111;
            3'd2:    s = 3'b010;
            3'd3:    s = 3'b100;
            3'd4:    s = 3'b110;
            3'd5:    s = 3'b001;
            3'd6:    s = 3'b101;
            default: s = 3'b011;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ src/oriented_box_transform_bounds.sv @@
// Top level of the oriented box bounds block: front end, compute engine
// and result queue. Depends on obtb_pkg, obtb_front, obtb_engine, obtb_fifo.
//
//   channel   handshake          word
//   input     push / full        in_word   (twelve matrix entries, Q16.16)
//   result    pop / empty        out_word  (kind, vx, vy, vz, last)
//   config    cfg_wr_en          cfg_index selects a corner coordinate, cfg_wdata
//
// Per matrix the engine makes 18 products on the one shared multiplier, 24 corner
// sums, and per edge three squares on the same multiplier, a 34-step square root
// and three dividers running FRAC_BITS + 1 steps.
// The input queue keeps accepting while the engine works; the result queue holds
// finished words while pop is low, and the engine stalls only when it is full.
// Reset clears the corner registers to zero and empties both queues.
`default_nettype none

module oriented_box_transform_bounds
    import obtb_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int IN_DEPTH  = 2,
    parameter int OUT_DEPTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_word_t    in_word,
    output logic             empty,
    input  wire logic        pop,
    output out_word_t        out_word,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    logic      q_valid, q_pop;
    in_word_t  q_word;
    box_cfg_t  box;
    logic      eng_push, out_full;
    out_word_t eng_word;

    obtb_front #(
        .IN_DEPTH (IN_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_word   (in_word),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .box       (box)
    );

    obtb_engine #(
        .FRAC_BITS (FRAC_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .box      (box),
        .in_valid (q_valid),
        .in_pop   (q_pop),
        .in_word  (q_word),
        .out_push (eng_push),
        .out_full (out_full),
        .out_word (eng_word)
    );

    obtb_fifo #(
        .W     ($bits(out_word_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (eng_push),
        .wr_data (eng_word),
        .full    (out_full),
        .rd_en   (pop),
        .rd_data (out_word),
        .empty   (empty)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        eng_push |-> !out_full)
        else $error("engine wrote a word into a full result queue");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("engine took a matrix from an empty input queue");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.last == (out_word.kind == KIND_HALF)))
        else $error("last flag does not match the half extent word");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.kind != 3'd7))
        else $error("result word carries an unused kind code");

endmodule

`default_nettype wire

@@ src/obtb_fifo.sv @@
// Register-based first-in first-out queue with a power-of-two depth.
// No dependencies.
`default_nettype none

module obtb_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         wr_en,
    input  wire logic [W-1:0] wr_data,
    output logic              full,
    input  wire logic         rd_en,
    output logic [W-1:0]      rd_data,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ src/obtb_front.sv @@
// Front end: corner registers and the queue of accepted matrix words.
// Depends on obtb_pkg and obtb_fifo.
`default_nettype none

module obtb_front
    import obtb_pkg::*;
#(
    parameter int IN_DEPTH = 2
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_word_t  in_word,
    input  wire logic      cfg_wr_en,
    input  wire logic [2:0] cfg_index,
    input  wire logic [31:0] cfg_wdata,
    output logic           q_valid,
    input  wire logic      q_pop,
    output in_word_t       q_word,
    output box_cfg_t       box
);

    box_cfg_t box_reg;
    logic     q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_A_X: box_reg.a[0] <= cfg_wdata;
                REG_A_Y: box_reg.a[1] <= cfg_wdata;
                REG_A_Z: box_reg.a[2] <= cfg_wdata;
                REG_B_X: box_reg.b[0] <= cfg_wdata;
                REG_B_Y: box_reg.b[1] <= cfg_wdata;
                REG_B_Z: box_reg.b[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign box     = box_reg;
    assign q_valid = !q_empty;

    obtb_fifo #(
        .W     ($bits(in_word_t)),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (in_word),
        .full    (full),
        .rd_en   (q_pop),
        .rd_data (q_word),
        .empty   (q_empty)
    );

endmodule

`default_nettype wire

@@ src/obtb_engine.sv @@
// Back end: sequencer with one shared multiplier, a bit-serial square root
// and three bit-serial dividers. Depends on obtb_pkg.
`default_nettype none

module obtb_engine
    import obtb_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire box_cfg_t box,
    input  wire logic     in_valid,
    output logic          in_pop,
    input  wire in_word_t in_word,
    output logic          out_push,
    input  wire logic     out_full,
    output out_word_t     out_word
);

    localparam int FB = FRAC_BITS;
    localparam int QW = FB + 1;
    localparam int NW = 32 + FB + 1;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_XF   = 7'b0000100,
        ST_SQ   = 7'b0001000,
        ST_ROOT = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;
    logic [1:0]  row_reg;
    logic [2:0]  corner_reg;
    logic [1:0]  edge_reg;
    kind_t       kind_reg;

    in_word_t           m_reg;
    logic signed [63:0] sl_reg [18];
    logic [2:0][31:0]   mx_reg, mn_reg, p1_reg, ext_reg;
    logic [2:0][2:0][31:0] far_reg, axis_reg;
    logic [2:0][31:0]   dmag_reg;
    logic [2:0]         dneg_reg;
    logic [63:0]        sq_reg;
    logic [65:0]        acc_reg;
    logic [67:0]        rad_reg;
    logic [36:0]        rem_reg;
    logic [33:0]        root_reg;
    logic [2:0][34:0]   drem_reg;
    logic [2:0][QW-1:0] dlow_reg;
    logic [2:0][QW-1:0] dq_reg;

    function automatic logic signed [31:0] m_elem(input in_word_t m, input logic [1:0] r,
                                                  input logic [1:0] c);
        logic signed [31:0] v;
        case ({r, c})
            4'b0000: v = m.m_r0_c0;
            4'b0001: v = m.m_r0_c1;
            4'b0010: v = m.m_r0_c2;
            4'b0011: v = m.m_r0_c3;
            4'b0100: v = m.m_r1_c0;
            4'b0101: v = m.m_r1_c1;
            4'b0110: v = m.m_r1_c2;
            4'b0111: v = m.m_r1_c3;
            4'b1000: v = m.m_r2_c0;
            4'b1001: v = m.m_r2_c1;
            4'b1010: v = m.m_r2_c2;
            default: v = m.m_r2_c3;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick3(input logic [2:0][31:0] v, input logic [1:0] i);
        logic [31:0] r;
        case (i)
            2'd0:    r = v[0];
            2'd1:    r = v[1];
            default: r = v[2];
        endcase
        return r;
    endfunction

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    // Edge difference for the component selected by the counter
    logic [31:0]        far_c, p1_c, d_mag;
    logic signed [32:0] d_val;

    // Corner transform
    logic [2:0]         sel;
    logic signed [63:0] tp0, tp1, tp2;
    logic signed [31:0] trans;
    logic signed [66:0] xsum, xv;
    logic [31:0]        coord;

    // Square root step
    logic [36:0] rt_r2, rt_trial;
    logic        rt_ge;

    // Divider lanes
    logic [NW-1:0]      div_num [3];
    logic [34:0]        div_r2  [3];
    logic [2:0]         div_ge;
    logic [34:0]        len35;
    logic [2:0][31:0]   ax_val;
    logic [32:0]        half;
    logic [31:0]        ext_val;

    logic [2:0][31:0]   cen;
    logic [2:0][31:0]   ov;
    logic [32:0]        span [3];

    always_comb
    begin
        far_c = pick3(far_reg[edge_reg], cnt_reg[1:0]);
        p1_c  = pick3(p1_reg, cnt_reg[1:0]);
        d_val = $signed({far_c[31], far_c}) - $signed({p1_c[31], p1_c});
        d_mag = d_val[32] ? 32'(-d_val) : d_val[31:0];

        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL:
            begin
                mul_a = 33'(m_elem(m_reg, row_reg, cnt_reg[2:1]));
                mul_b = cnt_reg[0] ? 33'($signed(pick3(box.b, cnt_reg[2:1])))
                                   : 33'($signed(pick3(box.a, cnt_reg[2:1])));
            end
            ST_SQ:
            begin
                mul_a = $signed({1'b0, d_mag});
                mul_b = $signed({1'b0, d_mag});
            end
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Rounding adds half an LSB and the translation at the binary point in one sum.
    always_comb
    begin
        sel   = corner_sel(corner_reg);
        tp0   = sel[0] ? sl_reg[1] : sl_reg[0];
        tp1   = sel[1] ? sl_reg[3] : sl_reg[2];
        tp2   = sel[2] ? sl_reg[5] : sl_reg[4];
        trans = m_elem(m_reg, row_reg, 2'd3);
        xsum  = 67'(tp0) + 67'(tp1) + 67'(tp2) + (67'(trans) << FB) + (67'(1) << (FB - 1));
        xv    = xsum >>> FB;
        if (xv[66:31] == '0 || xv[66:31] == '1)
        begin
            coord = xv[31:0];
        end
        else
        begin
            coord = xv[66] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    assign rt_r2    = {rem_reg[34:0], rad_reg[67:66]};
    assign rt_trial = {1'b0, root_reg, 2'b01};
    assign rt_ge    = (rt_r2 >= rt_trial);
    assign len35    = {1'b0, root_reg};

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            div_num[c] = (NW'(dmag_reg[c]) << FB) + NW'(root_reg[33:1]);
            div_r2[c]  = {drem_reg[c][33:0], dlow_reg[c][QW-1]};
            div_ge[c]  = (div_r2[c] >= len35);
            if (root_reg == '0)
            begin
                ax_val[c] = '0;
            end
            else
            begin
                ax_val[c] = dneg_reg[c] ? -32'(dq_reg[c]) : 32'(dq_reg[c]);
            end
            span[c] = $signed({mx_reg[c][31], mx_reg[c]}) - $signed({mn_reg[c][31], mn_reg[c]});
            cen[c]  = mn_reg[c] + span[c][32:1];
        end
        half    = root_reg[33:1];
        ext_val = (half[32:31] != 2'b00) ? 32'h7FFF_FFFF : half[31:0];
    end

    always_comb
    begin
        case (kind_reg)
            KIND_MAX:    ov = mx_reg;
            KIND_MIN:    ov = mn_reg;
            KIND_CENTER: ov = cen;
            KIND_AXIS_X: ov = axis_reg[0];
            KIND_AXIS_Y: ov = axis_reg[1];
            KIND_AXIS_Z: ov = axis_reg[2];
            KIND_HALF:   ov = ext_reg;
            default:     ov = '0;
        endcase
        out_word.kind = kind_reg;
        out_word.vx   = ov[0];
        out_word.vy   = ov[1];
        out_word.vz   = ov[2];
        out_word.last = (kind_reg == KIND_HALF);
    end

    assign in_pop   = (state_reg == ST_IDLE) && in_valid;
    assign out_push = (state_reg == ST_EMIT) && !out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            row_reg    <= '0;
            corner_reg <= '0;
            edge_reg   <= '0;
            kind_reg   <= KIND_MAX;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_MUL;
                        cnt_reg   <= '0;
                        row_reg   <= '0;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == 6'd5)
                    begin
                        cnt_reg <= '0;
                        if (row_reg == 2'd2)
                        begin
                            state_reg  <= ST_XF;
                            row_reg    <= '0;
                            corner_reg <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_XF:
                begin
                    corner_reg <= corner_reg + 3'd1;
                    if (corner_reg == 3'd7)
                    begin
                        if (row_reg == 2'd2)
                        begin
                            state_reg <= ST_SQ;
                            cnt_reg   <= '0;
                            edge_reg  <= '0;
                        end
                        else
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                end
                ST_SQ:
                begin
                    if (cnt_reg == 6'd3)
                    begin
                        state_reg <= ST_ROOT;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_ROOT:
                begin
                    if (cnt_reg == 6'd33)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_DIV:
                begin
                    if (cnt_reg == 6'(QW + 1))
                    begin
                        cnt_reg <= '0;
                        if (edge_reg == 2'd2)
                        begin
                            state_reg <= ST_EMIT;
                            kind_reg  <= KIND_MAX;
                        end
                        else
                        begin
                            state_reg <= ST_SQ;
                            edge_reg  <= edge_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                ST_EMIT:
                begin
                    if (!out_full)
                    begin
                        if (kind_reg == KIND_HALF)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            kind_reg <= kind_t'(kind_reg + 3'd1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    m_reg <= in_word;
                end
            end
            ST_MUL:
            begin
                // Products enter a shift line; row r ends at the head after its shift.
                sl_reg[17] <= mul_p[63:0];
                for (int j = 0; j < 17; j++)
                begin
                    sl_reg[j] <= sl_reg[j + 1];
                end
            end
            ST_XF:
            begin
                if (corner_reg == 3'd0)
                begin
                    mx_reg[row_reg] <= coord;
                    mn_reg[row_reg] <= coord;
                end
                else
                begin
                    if ($signed(coord) > $signed(mx_reg[row_reg]))
                    begin
                        mx_reg[row_reg] <= coord;
                    end
                    if ($signed(coord) < $signed(mn_reg[row_reg]))
                    begin
                        mn_reg[row_reg] <= coord;
                    end
                end
                case (corner_reg)
                    3'd1:    p1_reg[row_reg]     <= coord;
                    3'd4:    far_reg[0][row_reg] <= coord;
                    3'd6:    far_reg[1][row_reg] <= coord;
                    3'd7:    far_reg[2][row_reg] <= coord;
                    default: ;
                endcase
                if (corner_reg == 3'd7)
                begin
                    for (int j = 0; j < 12; j++)
                    begin
                        sl_reg[j] <= sl_reg[j + 6];
                    end
                end
            end
            ST_SQ:
            begin
                if (cnt_reg != 6'd3)
                begin
                    sq_reg                 <= mul_p[63:0];
                    dmag_reg[cnt_reg[1:0]] <= d_mag;
                    dneg_reg[cnt_reg[1:0]] <= d_val[32];
                end
                if (cnt_reg == 6'd0)
                begin
                    acc_reg <= '0;
                end
                else if (cnt_reg == 6'd3)
                begin
                    rad_reg  <= {2'b00, acc_reg + 66'(sq_reg)};
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg + 66'(sq_reg);
                end
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[65:0], 2'b00};
                rem_reg  <= rt_ge ? rt_r2 - rt_trial : rt_r2;
                root_reg <= {root_reg[32:0], rt_ge};
            end
            ST_DIV:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        drem_reg[c] <= 35'(div_num[c] >> QW);
                        dlow_reg[c] <= div_num[c][QW-1:0];
                        dq_reg[c]   <= '0;
                    end
                    else if (cnt_reg != 6'(QW + 1))
                    begin
                        drem_reg[c] <= div_ge[c] ? div_r2[c] - len35 : div_r2[c];
                        dlow_reg[c] <= dlow_reg[c] << 1;
                        dq_reg[c]   <= {dq_reg[c][QW-2:0], div_ge[c]};
                    end
                end
                if (cnt_reg == 6'(QW + 1))
                begin
                    axis_reg[edge_reg] <= ax_val;
                    ext_reg[edge_reg]  <= ext_val;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire
